[hdl/lpbt_pkg.sv]
// Shared types and constants for the LRU page buffer table.
package lpbt_pkg;
  localparam int unsigned NumFramesDefault = 16;
  localparam int unsigned MaxPinsDefault   = 255;
  localparam int unsigned FileW = 8;
  localparam int unsigned PageW = 20;
  localparam int unsigned PinW  = 16;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_UNPIN   = 2'd1,
    MODE_DIRTY   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_NOBUF    = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_PIN_ZERO = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RANK,
    S_OUT
  } state_e;

  // Per-frame view handed from the frame store to the sequencer.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic             pin_zero;
    logic             tag_match;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
  } frame_view_t;
endpackage

[hdl/lpbt_frames.sv]
// Frame store: tags, pins, dirty marks and recency ranks, one frame read per cycle.
module lpbt_frames #(
  parameter int unsigned NumFrames = lpbt_pkg::NumFramesDefault,
  parameter int unsigned MaxPins   = lpbt_pkg::MaxPinsDefault,
  parameter int unsigned IdxW      = $clog2(NumFrames)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IdxW-1:0]          rd_idx_i,
  input  logic [lpbt_pkg::FileW-1:0] cmp_file_i,
  input  logic [lpbt_pkg::PageW-1:0] cmp_page_i,
  output lpbt_pkg::frame_view_t    view_o,
  output logic [IdxW-1:0]          rank_o,
  // commit operations on frame tgt_idx_i
  input  logic [IdxW-1:0]          tgt_idx_i,
  input  logic                     do_pin_inc_i,
  input  logic                     do_pin_dec_i,
  input  logic                     do_dirty_i,
  input  logic                     do_release_i,
  input  logic                     do_install_i,
  // rank update: ranks above thr drop by one at rd_idx_i; target takes top
  input  logic                     rank_step_i,
  input  logic [IdxW-1:0]          rank_thr_i,
  input  logic                     rank_top_i
);
  import lpbt_pkg::*;

  localparam logic [PinW-1:0] PinMax = PinW'(MaxPins);

  logic [NumFrames-1:0] valid_q, dirty_q;
  logic [PinW-1:0]  pin_q  [NumFrames];
  logic [IdxW-1:0]  rank_q [NumFrames];
  logic [FileW-1:0] file_q [NumFrames];
  logic [PageW-1:0] page_q [NumFrames];

  always_comb begin
    view_o.valid     = valid_q[rd_idx_i];
    view_o.dirty     = dirty_q[rd_idx_i];
    view_o.pin_zero  = (pin_q[rd_idx_i] == '0);
    view_o.file      = file_q[rd_idx_i];
    view_o.page      = page_q[rd_idx_i];
    view_o.tag_match = valid_q[rd_idx_i] && file_q[rd_idx_i] == cmp_file_i &&
                       page_q[rd_idx_i] == cmp_page_i;
    rank_o           = rank_q[rd_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (do_install_i) begin
      file_q[tgt_idx_i] <= cmp_file_i;
      page_q[tgt_idx_i] <= cmp_page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        pin_q[i]  <= '0;
        rank_q[i] <= IdxW'(i);
      end
    end else begin
      if (do_install_i) begin
        valid_q[tgt_idx_i] <= 1'b1;
        dirty_q[tgt_idx_i] <= 1'b0;
        pin_q[tgt_idx_i]   <= PinW'(1);
      end
      if (do_pin_inc_i && pin_q[tgt_idx_i] < PinMax) begin
        pin_q[tgt_idx_i] <= pin_q[tgt_idx_i] + PinW'(1);
      end
      if (do_pin_dec_i) begin
        pin_q[tgt_idx_i] <= pin_q[tgt_idx_i] - PinW'(1);
      end
      if (do_dirty_i) begin
        dirty_q[tgt_idx_i] <= 1'b1;
      end
      if (do_release_i) begin
        valid_q[tgt_idx_i] <= 1'b0;
        dirty_q[tgt_idx_i] <= 1'b0;
        pin_q[tgt_idx_i]   <= '0;
      end
      if (rank_step_i && rank_q[rd_idx_i] > rank_thr_i) begin
        rank_q[rd_idx_i] <= rank_q[rd_idx_i] - IdxW'(1);
      end
      if (rank_top_i) begin
        rank_q[tgt_idx_i] <= IdxW'(NumFrames - 1);
      end
    end
  end
endmodule

[hdl/lru_page_buffer_table.sv]
// LRU page buffer table top level: request sequencer over the frame store.
// Usage: one request beat (mode, file_id, page_number) is taken on in_valid_i
// when in_stall_o is low; one result beat leaves on out_valid_o, taken when
// out_stall_i is low. The block works on one request at a time.
// A scan pass visits one frame a cycle for the tag match, free frame and
// victim search together; a get that changes the recency order (one that
// hits or installs) adds a second pass over the frames for the rank update.
// The decide step follows the scan, and the output step ends each request.
// The store's single frame read port is why each pass goes frame by frame.
// The result sits in an output register; in_stall_o stays high until it is
// taken, so a stalled receiver holds the whole block.
// Reset clears every frame to invalid, unpinned and clean, with ranks in
// frame order; the block leaves reset idle and ready for a request.
module lru_page_buffer_table #(
  parameter int unsigned NUM_FRAMES = lpbt_pkg::NumFramesDefault,
  parameter int unsigned MAX_PINS   = lpbt_pkg::MaxPinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  file_id_i,
  input  logic [19:0] page_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  frame_index_o,
  output logic        writeback_needed_o,
  output logic [7:0]  writeback_file_o,
  output logic [19:0] writeback_page_o
);
  import lpbt_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_FRAMES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  mode_e mode_q;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;

  logic hit_q, free_q, vic_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, vic_idx_q, vic_rank_q;
  logic [IdxW-1:0] tgt_q, thr_q;

  logic [2:0] status_q;
  logic [3:0] frame_q;
  logic wb_q;
  logic [FileW-1:0] wbf_q;
  logic [PageW-1:0] wbp_q;

  frame_view_t view;
  logic [IdxW-1:0] rank;
  logic [IdxW-1:0] rd_idx;

  // pin-zero, dirty mark and rank of the hit frame, latched during the scan
  logic hit_pz_q, hit_dirty_q;
  logic view_pin_zero_hit;
  logic [IdxW-1:0] rank_of_hit;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // decide-time choices
  logic [IdxW-1:0] slot;
  logic get_go, do_rank;
  always_comb begin
    slot    = free_q ? free_idx_q : vic_idx_q;
    get_go  = hit_q || free_q || vic_q;
    do_rank = (mode_q == MODE_GET) && get_go;
  end

  logic pin_inc, pin_dec, set_dirty, rel, install, rank_step, rank_top;
  always_comb begin
    pin_inc   = 1'b0;
    pin_dec   = 1'b0;
    set_dirty = 1'b0;
    rel       = 1'b0;
    install   = 1'b0;
    rank_step = 1'b0;
    rank_top  = 1'b0;
    rd_idx    = idx_q;
    case (state_q)
      S_DECIDE: begin
        rd_idx = slot;
        if (hit_q) begin
          case (mode_q)
            MODE_GET:     pin_inc   = 1'b1;
            MODE_UNPIN:   pin_dec   = !view_pin_zero_hit;
            MODE_DIRTY:   set_dirty = 1'b1;
            MODE_RELEASE: rel       = 1'b1;
            default: ;
          endcase
        end else if (mode_q == MODE_GET && get_go) begin
          install = 1'b1;
        end
      end
      S_RANK: begin
        rank_step = 1'b1;
        rank_top  = (idx_q == LastIdx);
      end
      default: ;
    endcase
  end

  assign view_pin_zero_hit = hit_pz_q;

  lpbt_frames #(
    .NumFrames(NUM_FRAMES),
    .MaxPins  (MAX_PINS),
    .IdxW     (IdxW)
  ) u_frames (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_idx_i    (rd_idx),
    .cmp_file_i  (file_q),
    .cmp_page_i  (page_q),
    .view_o      (view),
    .rank_o      (rank),
    .tgt_idx_i   ((state_q == S_RANK) ? tgt_q : (hit_q ? hit_idx_q : slot)),
    .do_pin_inc_i(pin_inc),
    .do_pin_dec_i(pin_dec),
    .do_dirty_i  (set_dirty),
    .do_release_i(rel),
    .do_install_i(install),
    .rank_step_i (rank_step),
    .rank_thr_i  (thr_q),
    .rank_top_i  (rank_top)
  );

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (idx_q == LastIdx) state_d = S_DECIDE;
        else idx_d = idx_q + IdxW'(1);
      end
      S_DECIDE: begin
        idx_d   = '0;
        state_d = do_rank ? S_RANK : S_OUT;
      end
      S_RANK: begin
        if (idx_q == LastIdx) state_d = S_OUT;
        else idx_d = idx_q + IdxW'(1);
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
  end

  assign status_o           = status_q;
  assign frame_index_o      = frame_q;
  assign writeback_needed_o = wb_q;
  assign writeback_file_o   = wbf_q;
  assign writeback_page_o   = wbp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (in_acc) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (view.tag_match && !hit_q) hit_q <= 1'b1;
        if (!view.valid && !free_q) free_q <= 1'b1;
        if (view.valid && view.pin_zero && (!vic_q || rank < vic_rank_q)) vic_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_e'(mode_i);
      file_q <= file_id_i;
      page_q <= page_number_i;
    end
    if (state_q == S_SCAN) begin
      // keep the first match and first free frame; lowest rank victim
      if (view.tag_match && !hit_q) begin
        hit_idx_q   <= idx_q;
        hit_pz_q    <= view.pin_zero;
        hit_dirty_q <= view.dirty;
        wbf_q       <= view.file;
        wbp_q       <= view.page;
      end
      if (!view.valid && !free_q) free_idx_q <= idx_q;
      if (view.valid && view.pin_zero && (!vic_q || rank < vic_rank_q)) begin
        vic_idx_q  <= idx_q;
        vic_rank_q <= rank;
      end
    end
    if (state_q == S_DECIDE) begin
      tgt_q    <= hit_q ? hit_idx_q : slot;
      thr_q    <= hit_q ? rank_of_hit : rank;
      wb_q     <= 1'b0;
      status_q <= ST_OK;
      frame_q  <= 4'(hit_idx_q);
      if (hit_q) begin
        if (mode_q == MODE_UNPIN && hit_pz_q) status_q <= ST_PIN_ZERO;
        if (mode_q == MODE_RELEASE && hit_dirty_q) wb_q <= 1'b1;
        else begin
          wbf_q <= '0;
          wbp_q <= '0;
        end
      end else if (mode_q != MODE_GET) begin
        status_q <= ST_ABSENT;
        frame_q  <= '0;
        wbf_q    <= '0;
        wbp_q    <= '0;
      end else if (!get_go) begin
        status_q <= ST_NOBUF;
        frame_q  <= '0;
        wbf_q    <= '0;
        wbp_q    <= '0;
      end else begin
        status_q <= ST_MISS;
        frame_q  <= 4'(slot);
        if (!free_q && view.dirty) begin
          wb_q  <= 1'b1;
          wbf_q <= view.file;
          wbp_q <= view.page;
        end else begin
          wbf_q <= '0;
          wbp_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && view.tag_match && !hit_q) rank_of_hit <= rank;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_nobuf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOBUF |-> !writeback_needed_o && frame_index_o == 4'd0)
    else $error("no-buffer result carries data");
endmodule

[tb/lpbt_checker.sv]
// Checker for the LRU page buffer table: watches both channels, predicts and compares results.
module lpbt_checker #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned MAX_PINS   = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  file_id_i,
  input  logic [19:0] page_number_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  frame_index_i,
  input  logic        writeback_needed_i,
  input  logic [7:0]  writeback_file_i,
  input  logic [19:0] writeback_page_i,
  output int          fail_count_o,
  output int          pending_o
);
  import lpbt_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        wb;
    logic [7:0]  wb_file;
    logic [19:0] wb_page;
  } lookup_result_t;

  logic        fr_valid [NUM_FRAMES];
  logic [7:0]  fr_file  [NUM_FRAMES];
  logic [19:0] fr_page  [NUM_FRAMES];
  int unsigned fr_pins  [NUM_FRAMES];
  logic        fr_dirty [NUM_FRAMES];
  int unsigned fr_rank  [NUM_FRAMES];

  lookup_result_t expected_results[$];

  function automatic void promote(int k);
    int unsigned r;
    r = fr_rank[k];
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_rank[i] > r) fr_rank[i]--;
    fr_rank[k] = NUM_FRAMES - 1;
  endfunction

  function automatic lookup_result_t apply_request(mode_e m, logic [7:0] f, logic [19:0] p);
    lookup_result_t res;
    int k;
    int slot;
    int unsigned best;
    res = '0;
    k = -1;
    slot = -1;
    best = 0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--)
      if (fr_valid[i] && fr_file[i] == f && fr_page[i] == p) k = i;
    if (m == MODE_GET) begin
      if (k >= 0) begin
        if (fr_pins[k] < MAX_PINS) fr_pins[k]++;
        promote(k);
        res.status = ST_OK;
        res.frame = 4'(k);
      end else begin
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
          if (!fr_valid[i]) slot = i;
        if (slot < 0) begin
          for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_valid[i] && fr_pins[i] == 0 && (slot < 0 || fr_rank[i] < best)) begin
              slot = i;
              best = fr_rank[i];
            end
          if (slot >= 0 && fr_dirty[slot]) begin
            res.wb = 1'b1;
            res.wb_file = fr_file[slot];
            res.wb_page = fr_page[slot];
          end
        end
        if (slot < 0) begin
          res.status = ST_NOBUF;
        end else begin
          fr_valid[slot] = 1'b1;
          fr_file[slot] = f;
          fr_page[slot] = p;
          fr_pins[slot] = 1;
          fr_dirty[slot] = 1'b0;
          promote(slot);
          res.status = ST_MISS;
          res.frame = 4'(slot);
        end
      end
    end else if (k < 0) begin
      res.status = ST_ABSENT;
    end else if (m == MODE_UNPIN) begin
      res.frame = 4'(k);
      if (fr_pins[k] == 0) begin
        res.status = ST_PIN_ZERO;
      end else begin
        fr_pins[k]--;
        res.status = ST_OK;
      end
    end else if (m == MODE_DIRTY) begin
      fr_dirty[k] = 1'b1;
      res.status = ST_OK;
      res.frame = 4'(k);
    end else begin
      if (fr_dirty[k]) begin
        res.wb = 1'b1;
        res.wb_file = fr_file[k];
        res.wb_page = fr_page[k];
      end
      fr_valid[k] = 1'b0;
      fr_pins[k] = 0;
      fr_dirty[k] = 1'b0;
      res.status = ST_OK;
      res.frame = 4'(k);
    end
    return res;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_res;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_results.delete();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fr_valid[i] = 1'b0;
        fr_file[i] = '0;
        fr_page[i] = '0;
        fr_pins[i] = 0;
        fr_dirty[i] = 1'b0;
        fr_rank[i] = i;
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (status_i !== exp_res.status ||
              frame_index_i !== exp_res.frame ||
              writeback_needed_i !== exp_res.wb ||
              writeback_file_i !== exp_res.wb_file ||
              writeback_page_i !== exp_res.wb_page)
            fail_count_o <= fail_count_o + 1;
          if (status_i !== exp_res.status)
            $error("status: expected %0d, got %0d", exp_res.status, status_i);
          if (frame_index_i !== exp_res.frame)
            $error("frame_index: expected %0d, got %0d", exp_res.frame, frame_index_i);
          if (writeback_needed_i !== exp_res.wb)
            $error("writeback_needed: expected %0d, got %0d", exp_res.wb,
                   writeback_needed_i);
          if (writeback_file_i !== exp_res.wb_file)
            $error("writeback_file: expected %0h, got %0h", exp_res.wb_file,
                   writeback_file_i);
          if (writeback_page_i !== exp_res.wb_page)
            $error("writeback_page: expected %0h, got %0h", exp_res.wb_page,
                   writeback_page_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_request(mode_e'(mode_i), file_id_i, page_number_i));
    end
  end
endmodule

[tb/tb_lru_page_buffer_table.sv]
// Testbench top for the LRU page buffer table: request stimulus, receiver stalls and verdict.
module tb_lru_page_buffer_table;
  import lpbt_pkg::*;

  localparam int RandomItems = 450;
  localparam int CycleLimit  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  file_id_i;
  logic [19:0] page_number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [3:0]  frame_index_o;
  logic        writeback_needed_o;
  logic [7:0]  writeback_file_o;
  logic [19:0] writeback_page_o;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          calm;

  // small tag pool so hits, pins and evictions happen often
  logic [7:0]  pool_file [24];
  logic [19:0] pool_page [24];

  lru_page_buffer_table dut (.*);

  lpbt_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .file_id_i,
    .page_number_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .frame_index_i(frame_index_o), .writeback_needed_i(writeback_needed_o),
    .writeback_file_i(writeback_file_o), .writeback_page_i(writeback_page_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stalls, with a calm stretch during which it never stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 28);
  end

  // drop valid after the beat, then idle; the idle gap is random unless calm
  task automatic send_request(mode_e m, logic [7:0] f, logic [19:0] p);
    in_valid_i <= 1'b1;
    mode_i <= m;
    file_id_i <= f;
    page_number_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (!calm && $urandom_range(99) < 28);
  endtask

  task automatic send_pooled(mode_e m);
    int j;
    j = $urandom_range(23);
    send_request(m, pool_file[j], pool_page[j]);
  endtask

  initial begin
    int r;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_GET;
    file_id_i = '0;
    page_number_i = '0;
    for (int j = 0; j < 24; j++) begin
      pool_file[j] = (j < 2) ? (j == 0 ? 8'h00 : 8'hff) : 8'($urandom);
      pool_page[j] = (j < 2) ? (j == 0 ? 20'h0 : 20'hfffff) : 20'($urandom);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: absent tags, extreme tags, fill, pin overflow, unpin at zero, eviction
    send_request(MODE_UNPIN, 8'hff, 20'hfffff);
    send_request(MODE_DIRTY, 8'h00, 20'h0);
    send_request(MODE_RELEASE, 8'h55, 20'haaaaa);
    send_request(MODE_GET, 8'h00, 20'h0);
    send_request(MODE_GET, 8'hff, 20'hfffff);
    send_request(MODE_DIRTY, 8'hff, 20'hfffff);
    send_request(MODE_RELEASE, 8'hff, 20'hfffff);
    send_request(MODE_UNPIN, 8'h00, 20'h0);
    send_request(MODE_UNPIN, 8'h00, 20'h0);
    send_request(MODE_GET, 8'h00, 20'h0);
    for (int j = 1; j < 16; j++) send_request(MODE_GET, 8'(j), 20'(j));
    send_request(MODE_GET, 8'h77, 20'h77777);
    for (int j = 1; j < 4; j++) begin
      send_request(MODE_DIRTY, 8'(j), 20'(j));
      send_request(MODE_UNPIN, 8'(j), 20'(j));
    end
    send_request(MODE_GET, 8'h77, 20'h77777);
    send_request(MODE_GET, 8'h78, 20'h77777);
    for (int j = 0; j < 300; j++) send_request(MODE_GET, 8'h05, 20'h5);
    send_request(MODE_RELEASE, 8'h05, 20'h5);

    // hold off until every expected result is back
    while (pending != 0) @(posedge clk_i);
    for (int j = 1; j < 16; j++) send_request(MODE_RELEASE, 8'(j), 20'(j));

    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 300 && n < 420);
      r = $urandom_range(99);
      if (r < 45) send_pooled(MODE_GET);
      else if (r < 75) send_pooled(MODE_UNPIN);
      else if (r < 85) send_pooled(MODE_DIRTY);
      else if (r < 95) send_pooled(MODE_RELEASE);
      else send_request(mode_e'($urandom_range(3)), 8'($urandom), 20'($urandom));
    end
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
